@@ rtl/core/rgbb_pkg.sv @@
// Shared types, constants and the helper function of the RGB 3x3 box blur.
package rgbb_pkg;

    // Default size limits of the line stores and the row counter.
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Configuration register port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_DATA_W-1:0] IMAGE_SIZE_RESET = 11'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } cfg_idx_t;

    // Fixed field widths of the result beat and the channel sums.
    localparam int CHAN_W = 8;
    localparam int POS_W  = 10;
    localparam int SUM_W  = 12;

    // Result queue depth.
    localparam int FIFO_DEPTH = 8;

    // Reciprocal of nine in 16 fractional bits; exact floor for sums up to 9 * 255.
    localparam logic [12:0] DIV9_RECIP = 13'd7282;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } pix_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic [POS_W-1:0]  out_row;
        logic [POS_W-1:0]  out_col;
        logic              last_of_image;
    } res_t;

    // Floor of a nine-pixel channel sum divided by nine.
    function automatic logic [CHAN_W-1:0] div9(input logic [SUM_W-1:0] s);
        logic [24:0] p;
        p = 25'(s) * 25'(DIV9_RECIP);
        return p[23:16];
    endfunction

endpackage

@@ rtl/core/rgbb_if.sv @@
// Channel interfaces of the box blur: pixel input, result output and configuration writes.
interface rgbb_pix_if;
    import rgbb_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rgbb_res_if;
    import rgbb_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic [POS_W-1:0]  out_row;
    logic [POS_W-1:0]  out_col;
    logic              last_of_image;
    modport source (output valid, out_red, out_green, out_blue, out_row, out_col,
                    last_of_image, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_row, out_col,
                    last_of_image, output ready);
endinterface

interface rgbb_cfg_if;
    import rgbb_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/rgb_box_blur_3x3.sv @@
// Pixel path: window update, window sums, divide by nine, then the result queue.
// Throughput: one pixel per clock while pix.ready is high; each pixel does one read and one write of each line store.
// The result queue holds 8 beats; outside reset, input ready drops only when results back up into it.
// Reset (rst_n low, asynchronous) clears the counters, window, pipeline and result queue,
// and sets both image sizes to 1024. The line stores are not cleared and need no sweep.
module rgb_box_blur_3x3 #(
    parameter int MAX_WIDTH  = rgbb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rgbb_pkg::MAX_HEIGHT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    rgbb_cfg_if.sink           cfg,
    rgbb_pix_if.sink           pix,
    rgbb_res_if.source         res
);
    import rgbb_pkg::*;

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int WSZ  = $clog2(MAX_WIDTH + 1);
    localparam int HSZ  = $clog2(MAX_HEIGHT + 1);
    localparam int WA   = ((WSZ > CFG_DATA_W) ? WSZ : CFG_DATA_W) + 1;
    localparam int HA   = ((HSZ > CFG_DATA_W) ? HSZ : CFG_DATA_W) + 1;
    localparam int PW   = $clog2(FIFO_DEPTH);
    localparam int CW   = $clog2(FIFO_DEPTH + 1);

    // Configuration registers.
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;

    // Position of the next pixel.
    logic [AW-1:0] col_reg;
    logic [RW-1:0] row_reg;

    // Stage 1: line store read data arrives, window and line stores update.
    logic              v1_reg;
    logic              emit1_reg;
    logic              last1_reg;
    logic [POS_W-1:0]  row1_reg;
    logic [POS_W-1:0]  col1_reg;
    pix_t              cur1_reg;
    logic [AW-1:0]     addr1_reg;
    pix_t              up_rd_reg;
    pix_t              lo_rd_reg;
    logic              fwd_hit_reg;
    pix_t              fwd_up_reg;
    pix_t              fwd_lo_reg;

    // Line stores.
    pix_t upper_mem [MAX_WIDTH];
    pix_t lower_mem [MAX_WIDTH];

    // Window, row-major, newest column on the right.
    pix_t win_reg [9];

    // Stage 2: window sums.
    logic             v2_reg;
    logic             last2_reg;
    logic [POS_W-1:0] row2_reg;
    logic [POS_W-1:0] col2_reg;

    // Stage 3: divide by nine and push.
    logic             v3_reg;
    logic             last3_reg;
    logic [POS_W-1:0] row3_reg;
    logic [POS_W-1:0] col3_reg;
    logic [SUM_W-1:0] sum_r_reg;
    logic [SUM_W-1:0] sum_g_reg;
    logic [SUM_W-1:0] sum_b_reg;

    // Result queue.
    res_t          fifo_mem [FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    logic pix_fire;
    logic res_fire;
    logic cfg_fire;

    logic [WA-1:0] w_cfg;
    logic [WA-1:0] w_eff;
    logic [HA-1:0] h_cfg;
    logic [HA-1:0] h_eff;
    logic [WA-1:0] c_ext;
    logic [HA-1:0] r_ext;
    logic          emit0;
    logic          last0;
    logic          col_wrap;
    logic          row_wrap;
    logic [AW-1:0] col_next;
    logic [RW-1:0] row_next;

    pix_t up_val;
    pix_t lo_val;

    logic [SUM_W-1:0] col_r [3];
    logic [SUM_W-1:0] col_g [3];
    logic [SUM_W-1:0] col_b [3];
    logic [SUM_W-1:0] sum_r_next;
    logic [SUM_W-1:0] sum_g_next;
    logic [SUM_W-1:0] sum_b_next;

    res_t           push_beat;
    logic [CW:0]    in_flight;

    assign cfg_fire = cfg.valid && cfg.ready;
    assign pix_fire = pix.valid && pix.ready;
    assign res_fire = res.valid && res.ready;

    assign cfg.ready = rst_n;

    // Configuration writes; indexes outside the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= IMAGE_SIZE_RESET;
            height_reg <= IMAGE_SIZE_RESET;
        end
        else if (cfg_fire)
        begin
            case (cfg.index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg.data;
                CFG_IMAGE_HEIGHT: height_reg <= cfg.data;
                default:          ;
            endcase
        end
    end

    // Effective sizes: zero counts as one, large values saturate to MAX_WIDTH and MAX_HEIGHT.
    always_comb
    begin
        w_cfg = WA'(width_reg);
        h_cfg = HA'(height_reg);
        if (w_cfg == '0)
            w_eff = WA'(1);
        else if (w_cfg > WA'(MAX_WIDTH))
            w_eff = WA'(MAX_WIDTH);
        else
            w_eff = w_cfg;
        if (h_cfg == '0)
            h_eff = HA'(1);
        else if (h_cfg > HA'(MAX_HEIGHT))
            h_eff = HA'(MAX_HEIGHT);
        else
            h_eff = h_cfg;
    end

    // Interior test and raster position advance for the incoming pixel.
    always_comb
    begin
        c_ext    = WA'(col_reg);
        r_ext    = HA'(row_reg);
        emit0    = (r_ext >= HA'(3)) && (r_ext + HA'(2) <= h_eff) &&
                   (c_ext >= WA'(3)) && (c_ext + WA'(2) <= w_eff);
        last0    = (r_ext + HA'(2) == h_eff) && (c_ext + WA'(2) == w_eff);
        col_wrap = (c_ext + WA'(1) >= w_eff);
        row_wrap = (r_ext + HA'(1) >= h_eff);
        col_next = col_wrap ? '0 : AW'(c_ext + WA'(1));
        if (!col_wrap)
            row_next = row_reg;
        else if (row_wrap)
            row_next = '0;
        else
            row_next = RW'(r_ext + HA'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (pix_fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Stage 1 control and the incoming pixel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            emit1_reg   <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= pix_fire;
            if (pix_fire)
            begin
                emit1_reg   <= emit0;
                fwd_hit_reg <= v1_reg && (addr1_reg == col_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            last1_reg  <= last0;
            row1_reg   <= POS_W'(row_reg - RW'(1));
            col1_reg   <= POS_W'(col_reg - AW'(1));
            cur1_reg   <= '{r: pix.red, g: pix.green, b: pix.blue};
            addr1_reg  <= col_reg;
            fwd_up_reg <= lo_val;
            fwd_lo_reg <= cur1_reg;
        end
    end

    // A write by the previous pixel to the same column lands at the read edge; take it
    // from the forward registers instead of the stale read data.
    assign up_val = fwd_hit_reg ? fwd_up_reg : up_rd_reg;
    assign lo_val = fwd_hit_reg ? fwd_lo_reg : lo_rd_reg;

    // Line stores: read at acceptance, written back in the following cycle.
    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            up_rd_reg <= upper_mem[col_reg];
            lo_rd_reg <= lower_mem[col_reg];
        end
        if (v1_reg)
        begin
            upper_mem[addr1_reg] <= lo_val;
            lower_mem[addr1_reg] <= cur1_reg;
        end
    end

    // Window shift: columns move left, the new column enters on the right.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
                win_reg[k] <= '0;
        end
        else if (v1_reg)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[k * 3]     <= win_reg[k * 3 + 1];
                win_reg[k * 3 + 1] <= win_reg[k * 3 + 2];
            end
            win_reg[2] <= up_val;
            win_reg[5] <= lo_val;
            win_reg[8] <= cur1_reg;
        end
    end

    // Stage 2 control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg && emit1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            last2_reg <= last1_reg;
            row2_reg  <= row1_reg;
            col2_reg  <= col1_reg;
        end
    end

    // Channel sums: column sums first, then across the three columns.
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            col_r[j] = SUM_W'(win_reg[j].r) + SUM_W'(win_reg[j + 3].r) +
                       SUM_W'(win_reg[j + 6].r);
            col_g[j] = SUM_W'(win_reg[j].g) + SUM_W'(win_reg[j + 3].g) +
                       SUM_W'(win_reg[j + 6].g);
            col_b[j] = SUM_W'(win_reg[j].b) + SUM_W'(win_reg[j + 3].b) +
                       SUM_W'(win_reg[j + 6].b);
        end
        sum_r_next = col_r[0] + col_r[1] + col_r[2];
        sum_g_next = col_g[0] + col_g[1] + col_g[2];
        sum_b_next = col_b[0] + col_b[1] + col_b[2];
    end

    // Stage 3 registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            last3_reg <= last2_reg;
            row3_reg  <= row2_reg;
            col3_reg  <= col2_reg;
            sum_r_reg <= sum_r_next;
            sum_g_reg <= sum_g_next;
            sum_b_reg <= sum_b_next;
        end
    end

    // Averages by reciprocal multiply.
    always_comb
    begin
        push_beat.out_red       = div9(sum_r_reg);
        push_beat.out_green     = div9(sum_g_reg);
        push_beat.out_blue      = div9(sum_b_reg);
        push_beat.out_row       = row3_reg;
        push_beat.out_col       = col3_reg;
        push_beat.last_of_image = last3_reg;
    end

    // Result queue storage.
    always_ff @(posedge clk)
    begin
        if (v3_reg)
            fifo_mem[wr_ptr_reg] <= push_beat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (v3_reg)
                wr_ptr_reg <= PW'(wr_ptr_reg + PW'(1));
            if (res_fire)
                rd_ptr_reg <= PW'(rd_ptr_reg + PW'(1));
            case ({v3_reg, res_fire})
                2'b10:   count_reg <= CW'(count_reg + CW'(1));
                2'b01:   count_reg <= CW'(count_reg - CW'(1));
                default: count_reg <= count_reg;
            endcase
        end
    end

    // Accept only while the queue has room for every beat already in the pipeline.
    assign in_flight = (CW + 1)'(count_reg) + (CW + 1)'(v1_reg) + (CW + 1)'(v2_reg) +
                       (CW + 1)'(v3_reg);
    assign pix.ready = rst_n && (in_flight < (CW + 1)'(FIFO_DEPTH));

    // Output beat.
    assign res.valid         = (count_reg != '0);
    assign res.out_red       = fifo_mem[rd_ptr_reg].out_red;
    assign res.out_green     = fifo_mem[rd_ptr_reg].out_green;
    assign res.out_blue      = fifo_mem[rd_ptr_reg].out_blue;
    assign res.out_row       = fifo_mem[rd_ptr_reg].out_row;
    assign res.out_col       = fifo_mem[rd_ptr_reg].out_col;
    assign res.last_of_image = fifo_mem[rd_ptr_reg].last_of_image;

endmodule

@@ rtl/core/rgbb_checker.sv @@
// Port-level assertions of the box blur and the bind that attaches them to the top level.
module rgbb_checker (
    input logic       clk,
    input logic       rst_n,
    rgbb_pix_if.sink  pix,
    rgbb_res_if.source res
);

    // A result that appears on an empty output comes from an accepted pixel beat.
    a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.valid) |-> $past(pix.valid && pix.ready, 4))
        else $error("result beat appeared without a pixel beat four cycles earlier");

    // Input backpressure only comes from results piling up at the output.
    a_stall_means_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        !pix.ready |-> res.valid)
        else $error("pixel input stalled while no result is waiting");

    // A waiting result stays offered.
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |=> res.valid)
        else $error("result valid dropped before the beat was taken");

    // A waiting result keeps its payload.
    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |=> $stable(res.out_red) && $stable(res.out_green) &&
        $stable(res.out_blue) && $stable(res.out_row) && $stable(res.out_col) &&
        $stable(res.last_of_image))
        else $error("result payload changed while stalled");

endmodule

bind rgb_box_blur_3x3 rgbb_checker u_rgbb_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .pix   (pix),
    .res   (res)
);
